// ----- design/crf_pkg.sv -----
// Shared types and constants for the CPU register file access core.
package crf_pkg;

	typedef enum logic [3:0] {
		CMD_RD_R8  = 4'd0,
		CMD_WR_R8  = 4'd1,
		CMD_RD_R16 = 4'd2,
		CMD_WR_R16 = 4'd3,
		CMD_RD_STK = 4'd4,
		CMD_WR_STK = 4'd5,
		CMD_RD_MEM = 4'd6,
		CMD_WR_MEM = 4'd7,
		CMD_COND   = 4'd8,
		CMD_SET_F  = 4'd9,
		CMD_CLR_F  = 4'd10
	} cmd_t;

	typedef enum logic [1:0] {
		MEM_NONE  = 2'd0,
		MEM_READ  = 2'd1,
		MEM_WRITE = 2'd2
	} mem_op_t;

	// 8-bit register indexes
	localparam logic [2:0] IDX_H   = 3'd4;
	localparam logic [2:0] IDX_L   = 3'd5;
	localparam logic [2:0] IDX_MEM = 3'd6;
	localparam logic [2:0] IDX_A   = 3'd7;

	// pair indexes
	localparam logic [2:0] PAIR_HL_INC = 3'd2;
	localparam logic [2:0] PAIR_LAST   = 3'd3;

	// condition codes
	localparam logic [2:0] COND_NZ = 3'd0;
	localparam logic [2:0] COND_Z  = 3'd1;
	localparam logic [2:0] COND_NC = 3'd2;
	localparam logic [2:0] COND_C  = 3'd3;

	localparam int FLAG_Z_BIT = 7;
	localparam int FLAG_C_BIT = 4;

	localparam logic [7:0] BYTE_MASK = 8'hFF;

	typedef struct packed {
		logic [7:0]      acc;
		logic [7:0]      flags;
		logic [5:0][7:0] gp;
		logic [15:0]     sp;
	} regs_t;

	typedef struct packed {
		logic [15:0] read_value;
		mem_op_t     mem_op;
		logic [15:0] mem_address;
		logic [7:0]  mem_write_data;
		logic        cond_met;
	} result_t;

endpackage

// ----- design/crf_exec.sv -----
// One command against the register file: next register state and the result item.
module crf_exec (
	input  logic [3:0]     cmd,
	input  logic [2:0]     reg_index,
	input  logic [15:0]    data_in,
	input  crf_pkg::regs_t cur,
	output crf_pkg::regs_t nxt,
	output crf_pkg::result_t res
);

	localparam logic [2:0] IDX_H_I = crf_pkg::IDX_H;
	localparam logic [2:0] IDX_L_I = crf_pkg::IDX_L;

	logic [7:0]  low;
	logic [15:0] hl;
	logic [15:0] hl_step;
	logic [15:0] pair_val;

	assign low = data_in[7:0];
	assign hl  = {cur.gp[IDX_H_I], cur.gp[IDX_L_I]};
	assign hl_step = (reg_index == crf_pkg::PAIR_HL_INC) ? hl + 16'd1 : hl - 16'd1;
	// BC, DE, HL by pair index 0..2
	assign pair_val = {cur.gp[{reg_index[1:0], 1'b0}], cur.gp[{reg_index[1:0], 1'b1}]};

	always_comb begin
		nxt = cur;
		res = '0;
		case (crf_pkg::cmd_t'(cmd))
			crf_pkg::CMD_RD_R8: begin
				if (reg_index == crf_pkg::IDX_MEM) begin
					res.mem_op      = crf_pkg::MEM_READ;
					res.mem_address = hl;
				end else if (reg_index == crf_pkg::IDX_A) begin
					res.read_value = {8'h00, cur.acc};
				end else begin
					res.read_value = {8'h00, cur.gp[reg_index]};
				end
			end
			crf_pkg::CMD_WR_R8: begin
				if (reg_index == crf_pkg::IDX_MEM) begin
					res.mem_op         = crf_pkg::MEM_WRITE;
					res.mem_address    = hl;
					res.mem_write_data = low;
				end else if (reg_index == crf_pkg::IDX_A) begin
					nxt.acc = low;
				end else begin
					nxt.gp[reg_index] = low;
				end
			end
			crf_pkg::CMD_RD_R16, crf_pkg::CMD_RD_STK: begin
				if (reg_index inside {[3'd0:3'd2]}) begin
					res.read_value = pair_val;
				end else if (reg_index == crf_pkg::PAIR_LAST) begin
					res.read_value = (crf_pkg::cmd_t'(cmd) == crf_pkg::CMD_RD_R16) ?
						cur.sp : {cur.acc, cur.flags};
				end
			end
			crf_pkg::CMD_WR_R16, crf_pkg::CMD_WR_STK: begin
				if (reg_index inside {[3'd0:3'd2]}) begin
					nxt.gp[{reg_index[1:0], 1'b0}] = data_in[15:8];
					nxt.gp[{reg_index[1:0], 1'b1}] = low;
				end else if (reg_index == crf_pkg::PAIR_LAST) begin
					if (crf_pkg::cmd_t'(cmd) == crf_pkg::CMD_WR_R16) begin
						nxt.sp = data_in;
					end else begin
						nxt.acc   = data_in[15:8];
						nxt.flags = low;
					end
				end
			end
			crf_pkg::CMD_RD_MEM, crf_pkg::CMD_WR_MEM: begin
				if (reg_index inside {[3'd0:3'd3]}) begin
					if (crf_pkg::cmd_t'(cmd) == crf_pkg::CMD_RD_MEM) begin
						res.mem_op = crf_pkg::MEM_READ;
					end else begin
						res.mem_op         = crf_pkg::MEM_WRITE;
						res.mem_write_data = low;
					end
					if (!reg_index[1]) begin
						res.mem_address = pair_val;
					end else begin
						// HL+ / HL-: address is HL before the step
						res.mem_address = hl;
						nxt.gp[IDX_H_I] = hl_step[15:8];
						nxt.gp[IDX_L_I] = hl_step[7:0];
					end
				end
			end
			crf_pkg::CMD_COND: begin
				case (reg_index)
					crf_pkg::COND_NZ: res.cond_met = ~cur.flags[crf_pkg::FLAG_Z_BIT];
					crf_pkg::COND_Z:  res.cond_met = cur.flags[crf_pkg::FLAG_Z_BIT];
					crf_pkg::COND_NC: res.cond_met = ~cur.flags[crf_pkg::FLAG_C_BIT];
					crf_pkg::COND_C:  res.cond_met = cur.flags[crf_pkg::FLAG_C_BIT];
					default:          res.cond_met = 1'b0;
				endcase
			end
			crf_pkg::CMD_SET_F: begin
				nxt.flags = cur.flags | low;
			end
			crf_pkg::CMD_CLR_F: begin
				nxt.flags = cur.flags & (~low & crf_pkg::BYTE_MASK);
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- design/cpu_register_file_access_core.sv -----
// Top level: input register, register file update and result register.
// Path: a command is registered in the input stage, then its result in the result register (result stage).
// Throughput: one command per cycle; each command is one pass of the register file logic
// between the input stage and the result register, so back-to-back commands see every
// earlier update. Output stalls hold the result register and back-pressure the input.
// Reset (arst_n low, asynchronous) clears A, F, B..L, SP and both valid flags.
module cpu_register_file_access_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  cmd,
	input  logic [2:0]  reg_index,
	input  logic [15:0] data_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] read_value,
	output logic [1:0]  mem_op,
	output logic [15:0] mem_address,
	output logic [7:0]  mem_write_data,
	output logic        cond_met
);

	logic              valid_s1;
	logic [3:0]        cmd_s1;
	logic [2:0]        reg_index_s1;
	logic [15:0]       data_in_s1;
	logic              out_valid_q;
	crf_pkg::result_t  res_q;
	crf_pkg::regs_t    regs_q;
	crf_pkg::regs_t    regs_nxt;
	crf_pkg::result_t  res_nxt;
	logic              advance;
	logic              fire_s1;

	// stage 1 moves on whenever the result register is free or being drained
	assign advance  = !out_valid_q || out_ready;
	assign fire_s1  = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	crf_exec u_exec (
		.cmd       (cmd_s1),
		.reg_index (reg_index_s1),
		.data_in   (data_in_s1),
		.cur       (regs_q),
		.nxt       (regs_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			regs_q      <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (fire_s1) begin
				regs_q <= regs_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1       <= cmd;
			reg_index_s1 <= reg_index;
			data_in_s1   <= data_in;
		end
		if (fire_s1) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign read_value     = res_q.read_value;
	assign mem_op         = res_q.mem_op;
	assign mem_address    = res_q.mem_address;
	assign mem_write_data = res_q.mem_write_data;
	assign cond_met       = res_q.cond_met;

endmodule

// ----- design/crf_checker.sv -----
// Port-level checks for the register file access core, bound to the top level.
module crf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] read_value,
	input logic [1:0]  mem_op,
	input logic [15:0] mem_address,
	input logic [7:0]  mem_write_data,
	input logic        cond_met
);

	// a stalled result holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_value) && $stable(mem_op)
			&& $stable(mem_address) && $stable(mem_write_data) && $stable(cond_met))
		else $error("result changed while stalled");

	// an empty result register never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	a_no_mem_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mem_op == crf_pkg::MEM_NONE |-> mem_address == 16'd0
			&& mem_write_data == 8'd0)
		else $error("memory fields set without a request");

	a_wdata_only_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mem_op != crf_pkg::MEM_WRITE |-> mem_write_data == 8'd0)
		else $error("write data without a write request");

	// a condition test reads nothing and requests no memory
	a_cond_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cond_met |-> read_value == 16'd0 && mem_op == crf_pkg::MEM_NONE)
		else $error("condition result mixed with other results");

endmodule

bind cpu_register_file_access_core crf_checker u_crf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.read_value     (read_value),
	.mem_op         (mem_op),
	.mem_address    (mem_address),
	.mem_write_data (mem_write_data),
	.cond_met       (cond_met)
);

// ----- tb/tb_cpu_register_file_access_core.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the CPU register file access core.
module tb_cpu_register_file_access_core;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 12;
	localparam int RANDOM_ITEMS  = 400;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 10;

	// pair selects: BC, DE, HL (HL+ on memory commands); PAIR_LAST is SP, AF or HL-
	localparam logic [2:0] PAIR_BC = 3'd0;
	localparam logic [2:0] PAIR_HL = crf_pkg::PAIR_HL_INC;
	// index past every pair and condition
	localparam logic [2:0] SEL_OUT_OF_RANGE = 3'd7;
	localparam logic [3:0] CMD_UNUSED = 4'd15;

	typedef struct {
		logic [3:0]  op;
		logic [2:0]  sel;
		logic [15:0] data;
		bit          drain;
	} reg_cmd_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [3:0]  cmd;
	logic [2:0]  reg_index;
	logic [15:0] data_in;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] read_value;
	logic [1:0]  mem_op;
	logic [15:0] mem_address;
	logic [7:0]  mem_write_data;
	logic        cond_met;

	reg_cmd_t         pending_cmds[$];
	crf_pkg::result_t expected_results[$];
	crf_pkg::regs_t   shadow_regs;

	logic       input_taken;
	int         burst_left;
	int         gap_left;
	logic [8:0] stall_phase;
	int         cycle_count;
	int         results_seen;
	int         mismatch_count;

	cpu_register_file_access_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.reg_index      (reg_index),
		.data_in        (data_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.read_value     (read_value),
		.mem_op         (mem_op),
		.mem_address    (mem_address),
		.mem_write_data (mem_write_data),
		.cond_met       (cond_met)
	);

	always #CLK_HALF clk = ~clk;

	function automatic logic [15:0] pair_value(input logic [2:0] sel);
		return {shadow_regs.gp[2 * sel], shadow_regs.gp[2 * sel + 1]};
	endfunction

	task automatic load_pair(input logic [2:0] sel, input logic [15:0] v);
		shadow_regs.gp[2 * sel]     = v[15:8];
		shadow_regs.gp[2 * sel + 1] = v[7:0];
	endtask

	// Applies one command to the shadow registers and returns the result it should give.
	task automatic predict_register_access(input reg_cmd_t c, output crf_pkg::result_t r);
		logic [7:0]  low;
		logic [15:0] hl;
		low = c.data[7:0];
		hl = pair_value(PAIR_HL);
		r = '0;
		r.mem_op = crf_pkg::MEM_NONE;
		case (c.op)
		crf_pkg::CMD_RD_R8: begin
			if (c.sel == crf_pkg::IDX_MEM) begin
				r.mem_op = crf_pkg::MEM_READ;
				r.mem_address = hl;
			end else if (c.sel == crf_pkg::IDX_A)
				r.read_value = {8'h00, shadow_regs.acc};
			else
				r.read_value = {8'h00, shadow_regs.gp[c.sel]};
		end
		crf_pkg::CMD_WR_R8: begin
			if (c.sel == crf_pkg::IDX_MEM) begin
				r.mem_op = crf_pkg::MEM_WRITE;
				r.mem_address = hl;
				r.mem_write_data = low;
			end else if (c.sel == crf_pkg::IDX_A)
				shadow_regs.acc = low;
			else
				shadow_regs.gp[c.sel] = low;
		end
		crf_pkg::CMD_RD_R16, crf_pkg::CMD_RD_STK: begin
			if (c.sel < crf_pkg::PAIR_LAST)
				r.read_value = pair_value(c.sel);
			else if (c.sel == crf_pkg::PAIR_LAST)
				r.read_value = (c.op == crf_pkg::CMD_RD_R16) ? shadow_regs.sp
					: {shadow_regs.acc, shadow_regs.flags};
		end
		crf_pkg::CMD_WR_R16, crf_pkg::CMD_WR_STK: begin
			if (c.sel < crf_pkg::PAIR_LAST)
				load_pair(c.sel, c.data);
			else if (c.sel == crf_pkg::PAIR_LAST) begin
				if (c.op == crf_pkg::CMD_WR_R16)
					shadow_regs.sp = c.data;
				else begin
					shadow_regs.acc = c.data[15:8];
					shadow_regs.flags = low;
				end
			end
		end
		crf_pkg::CMD_RD_MEM, crf_pkg::CMD_WR_MEM: begin
			if (c.sel <= crf_pkg::PAIR_LAST) begin
				r.mem_op = (c.op == crf_pkg::CMD_RD_MEM) ? crf_pkg::MEM_READ
					: crf_pkg::MEM_WRITE;
				if (c.op == crf_pkg::CMD_WR_MEM)
					r.mem_write_data = low;
				if (c.sel < PAIR_HL)
					r.mem_address = pair_value(c.sel);
				else begin
					// HL+ / HL- step after the address is taken, wrapping at 16 bits
					r.mem_address = hl;
					load_pair(PAIR_HL, (c.sel == PAIR_HL) ? hl + 16'd1 : hl - 16'd1);
				end
			end
		end
		crf_pkg::CMD_COND: begin
			case (c.sel)
			crf_pkg::COND_NZ: r.cond_met = !shadow_regs.flags[crf_pkg::FLAG_Z_BIT];
			crf_pkg::COND_Z:  r.cond_met = shadow_regs.flags[crf_pkg::FLAG_Z_BIT];
			crf_pkg::COND_NC: r.cond_met = !shadow_regs.flags[crf_pkg::FLAG_C_BIT];
			crf_pkg::COND_C:  r.cond_met = shadow_regs.flags[crf_pkg::FLAG_C_BIT];
			default: r.cond_met = 1'b0;
			endcase
		end
		crf_pkg::CMD_SET_F: shadow_regs.flags = shadow_regs.flags | low;
		crf_pkg::CMD_CLR_F: shadow_regs.flags = shadow_regs.flags & ~low;
		default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch on %0s, result %0d: got %h, expected %h",
			what, results_seen, got, want);
		mismatch_count++;
	endtask

	function automatic void add_cmd(input logic [3:0] op, input logic [2:0] sel,
			input logic [15:0] data, input bit drain = 1'b0);
		reg_cmd_t c;
		c.op = op;
		c.sel = sel;
		c.data = data;
		c.drain = drain;
		pending_cmds.push_back(c);
	endfunction

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// Output check first, then the new input transfer is predicted.
	always @(posedge clk) begin : monitor
		crf_pkg::result_t want;
		reg_cmd_t         taken;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0)
					report_mismatch("unexpected result", read_value, 16'h0000);
				else begin
					want = expected_results.pop_front();
					if (read_value !== want.read_value)
						report_mismatch("read_value", read_value, want.read_value);
					if (mem_op !== want.mem_op)
						report_mismatch("mem_op", {14'h0, mem_op}, {14'h0, want.mem_op});
					if (mem_address !== want.mem_address)
						report_mismatch("mem_address", mem_address, want.mem_address);
					if (mem_write_data !== want.mem_write_data)
						report_mismatch("mem_write_data", {8'h00, mem_write_data},
							{8'h00, want.mem_write_data});
					if (cond_met !== want.cond_met)
						report_mismatch("cond_met", {15'h0, cond_met}, {15'h0, want.cond_met});
				end
				results_seen++;
			end
			if (in_valid && in_ready) begin
				taken.op = cmd;
				taken.sel = reg_index;
				taken.data = data_in;
				taken.drain = 1'b0;
				predict_register_access(taken, want);
				expected_results.push_back(want);
			end
			input_taken <= in_valid && in_ready;
		end
	end

	// Sender: bursts of transfers separated by random gaps.
	always @(negedge clk) begin : driver
		reg_cmd_t next_cmd;
		if (arst_n) begin
			if (in_valid && !input_taken) begin
				// hold until the transfer happens
			end else if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_cmds.size() > 0 &&
					!(pending_cmds[0].drain && expected_results.size() > 0)) begin
				next_cmd = pending_cmds.pop_front();
				cmd <= next_cmd.op;
				reg_index <= next_cmd.sel;
				data_in <= next_cmd.data;
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else
					burst_left <= burst_left - 1;
			end else
				in_valid <= 1'b0;
		end
	end

	// Receiver: cycles through always-ready, random, periodic and mostly-stalled stretches.
	always @(negedge clk) begin
		if (arst_n) begin
			stall_phase <= stall_phase + 9'd1;
			case (stall_phase[8:7])
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= ($urandom_range(0, 1) == 1);
			2'd2: out_ready <= (stall_phase[1:0] != 2'd0);
			default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	initial begin : timeout
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		reg_cmd_t c;
		int       r;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = '0;
		reg_index = '0;
		data_in = '0;
		out_ready = 1'b0;
		input_taken = 1'b0;
		burst_left = 0;
		gap_left = 0;
		stall_phase = '0;
		cycle_count = 0;
		results_seen = 0;
		mismatch_count = 0;
		shadow_regs = '0;

		// every 8-bit register, alternating all-zero and all-one bytes
		for (int i = 0; i < 8; i++)
			if (3'(i) != crf_pkg::IDX_MEM)
				add_cmd(crf_pkg::CMD_WR_R8, 3'(i), (i % 2) ? 16'h00FF : 16'hFF00);
		add_cmd(crf_pkg::CMD_WR_R8, crf_pkg::IDX_MEM, 16'hFFFF);
		add_cmd(crf_pkg::CMD_RD_R8, crf_pkg::IDX_MEM, 16'h0000);
		add_cmd(crf_pkg::CMD_RD_R8, crf_pkg::IDX_A, 16'hFFFF);
		add_cmd(crf_pkg::CMD_WR_R16, crf_pkg::PAIR_LAST, 16'hFFFF);
		add_cmd(crf_pkg::CMD_RD_R16, crf_pkg::PAIR_LAST, 16'h0000);
		// HL+ wraps to zero, then HL- wraps back
		add_cmd(crf_pkg::CMD_WR_R16, PAIR_HL, 16'hFFFF);
		add_cmd(crf_pkg::CMD_RD_MEM, PAIR_HL, 16'h0000);
		add_cmd(crf_pkg::CMD_WR_MEM, crf_pkg::PAIR_LAST, 16'h1234);
		// AF write puts the whole low byte into F
		add_cmd(crf_pkg::CMD_WR_STK, crf_pkg::PAIR_LAST, 16'h80FF);
		add_cmd(crf_pkg::CMD_RD_STK, crf_pkg::PAIR_LAST, 16'h0000);
		for (int i = 0; i < 4; i++)
			add_cmd(crf_pkg::CMD_COND, 3'(i), 16'h0000);
		add_cmd(crf_pkg::CMD_CLR_F, PAIR_BC, 16'hFF90);
		add_cmd(crf_pkg::CMD_COND, crf_pkg::COND_NC, 16'h0000);
		add_cmd(crf_pkg::CMD_SET_F, PAIR_BC, 16'h0010);
		add_cmd(crf_pkg::CMD_COND, SEL_OUT_OF_RANGE, 16'h0000);
		add_cmd(crf_pkg::CMD_WR_R16, SEL_OUT_OF_RANGE, 16'hFFFF);
		add_cmd(crf_pkg::CMD_RD_MEM, SEL_OUT_OF_RANGE, 16'h0000);
		add_cmd(CMD_UNUSED, PAIR_BC, 16'hFFFF);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			r = $urandom_range(0, 99);
			c.op = (r < 92) ? 4'($urandom_range(0, 10)) : 4'($urandom_range(11, 15));
			if (c.op == crf_pkg::CMD_RD_R8 || c.op == crf_pkg::CMD_WR_R8 ||
					$urandom_range(0, 9) == 0)
				c.sel = 3'($urandom_range(0, 7));
			else
				c.sel = 3'($urandom_range(0, 3));
			r = $urandom_range(0, 7);
			c.data = (r == 0) ? 16'hFFFF : (r == 1) ? 16'h0000 : 16'($urandom);
			// drain all results before the random part and once midway
			add_cmd(c.op, c.sel, c.data, (n == 0) || (n == RANDOM_ITEMS / 2));
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
design/crf_pkg.sv
design/crf_exec.sv
design/cpu_register_file_access_core.sv
design/crf_checker.sv
tb/tb_cpu_register_file_access_core.sv
